// ===== design/mlfq_pkg.sv =====
// Package: payload types, status and operation codes for the thread scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;
	localparam int THREAD_SLOTS_DEF = 16;
	localparam int EVENT_COUNT_DEF = 8;
	localparam logic [15:0] QUANTUM_HIGH_RST = 16'd100;
	localparam logic [15:0] QUANTUM_MID_RST = 16'd200;
	localparam logic [15:0] QUANTUM_LOW_RST = 16'd300;
	localparam logic [7:0] TICK_MS_RST = 8'd10;

	typedef enum logic [3:0] {
		OP_CREATE = 4'd0, OP_CANCEL = 4'd1, OP_WAIT_EV = 4'd2, OP_SET_EV = 4'd3,
		OP_WAIT_TM = 4'd4, OP_TEST_CAN = 4'd5, OP_FINISH = 4'd6, OP_DISPATCH = 4'd7,
		OP_TICK = 4'd8, OP_RELEASE = 4'd9, OP_QUERY = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		TS_FREE = 3'd0, TS_READY = 3'd1, TS_RUN = 3'd2, TS_SLEEP = 3'd3,
		TS_EVWAIT = 3'd4, TS_TERM = 3'd5
	} tstat_t;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] CFG_QHIGH = 2'd0;
	localparam logic [1:0] CFG_QMID = 2'd1;
	localparam logic [1:0] CFG_QLOW = 2'd2;
	localparam logic [1:0] CFG_TICK = 2'd3;

	typedef struct packed {
		logic [3:0] operation;
		logic [3:0] target_thread;
		logic [1:0] priority_level;
		logic deferred_mode;
		logic [2:0] event_number;
		logic [15:0] wait_ticks;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] thread_slot;
		logic dispatched;
		logic [2:0] thread_status;
		logic [1:0] current_level;
		logic [1:0] base_level;
		logic [31:0] ready_time;
		logic [31:0] waiting_time;
	} rsp_t;

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [7:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {25'd0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction
endpackage

// ===== design/multilevel_feedback_thread_scheduler_core.sv =====
// Top level: thread table and sequencer that walks one slot per cycle.
// A request walks the table once for create, cancel, set event, release and query, and up to
// four times for wait, test cancel, finish and dispatch (scan, three levels). A tick walks it
// up to six times plus once per expiring sleeper.
// Throughput: one request at a time; in_ready is low until the result is taken.
// Reset (arst_n low) frees every slot, clears the stamp counter and loads default quanta.
`timescale 1ns / 1ps
module multilevel_feedback_thread_scheduler_core
	import mlfq_pkg::*;
#(
	parameter int THREAD_SLOTS = THREAD_SLOTS_DEF,
	parameter int EVENT_COUNT = EVENT_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsp_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	localparam int SW = $clog2(THREAD_SLOTS);
	localparam int EW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;

	// event number folded into the event range, built at elaboration
	function automatic logic [7:0][5:0] ev_fold_table();
		logic [7:0][5:0] m;
		for (int i = 0; i < 8; i++) m[i] = 6'(i % EVENT_COUNT);
		return m;
	endfunction

	localparam logic [7:0][5:0] EV_FOLD = ev_fold_table();

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001, S_SCAN = 8'b0000_0010, S_APPLY = 8'b0000_0100,
		S_WAKE = 8'b0000_1000, S_DISP = 8'b0001_0000, S_RESP = 8'b0010_0000,
		S_TICK2 = 8'b0100_0000, S_DONE = 8'b1000_0000
	} fsm_t;

	fsm_t state_q;
	tstat_t stat_q [THREAD_SLOTS];
	logic [1:0] lvl_q [THREAD_SLOTS];
	logic [1:0] base_q [THREAD_SLOTS];
	logic dfr_q [THREAD_SLOTS];
	logic creq_q [THREAD_SLOTS];
	logic [EW-1:0] aev_q [THREAD_SLOTS];
	logic [15:0] sleep_q [THREAD_SLOTS];
	logic [15:0] run_q [THREAD_SLOTS];
	logic [31:0] rdy_q [THREAD_SLOTS];
	logic [31:0] wt_q [THREAD_SLOTS];
	logic [31:0] stamp_q [THREAD_SLOTS];
	logic [31:0] stamp_cnt_q;
	logic [15:0] qh_q, qm_q, ql_q;
	logic [7:0] tick_q;

	req_t req_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] idx;
	logic [1:0] pass_q;          // tick pass
	logic hit_q, disp_q, busy_q, gone_v_q, run_v_q;
	logic [SW-1:0] best_q, gone_q, run_s_q, slot_q;
	logic [1:0] st_q;
	logic [31:0] best_age_q;
	logic [1:0] best_lvl_q;
	logic [2:0] disp_lvl_q;
	logic detail_q;
	logic [EW-1:0] ev;
	logic [31:0] age;
	logic last;

	assign idx = idx_q;
	assign last = (idx_q == SW'(THREAD_SLOTS - 1));
	assign age = stamp_cnt_q - stamp_q[idx];
	assign ev = EW'(EV_FOLD[req_q.event_number]);
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qh_q <= QUANTUM_HIGH_RST;
			qm_q <= QUANTUM_MID_RST;
			ql_q <= QUANTUM_LOW_RST;
			tick_q <= TICK_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_QHIGH: qh_q <= cfg_data;
				CFG_QMID: qm_q <= cfg_data;
				CFG_QLOW: ql_q <= cfg_data;
				CFG_TICK: tick_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	function automatic logic [15:0] quantum(logic [1:0] l, logic [15:0] a, logic [15:0] b,
			logic [15:0] c);
		return (l == 2'd0) ? a : ((l == 2'd1) ? b : c);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			stamp_cnt_q <= '0;
			for (int i = 0; i < THREAD_SLOTS; i++) stat_q[i] <= TS_FREE;
			idx_q <= '0;
			pass_q <= '0;
			hit_q <= 1'b0;
			disp_q <= 1'b0;
			busy_q <= 1'b0;
			gone_v_q <= 1'b0;
			run_v_q <= 1'b0;
			detail_q <= 1'b0;
			st_q <= ST_NONE;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
						idx_q <= '0;
						pass_q <= '0;
						hit_q <= 1'b0;
						disp_q <= 1'b0;
						busy_q <= 1'b0;
						gone_v_q <= 1'b0;
						run_v_q <= 1'b0;
						detail_q <= 1'b0;
						st_q <= ST_NONE;
						state_q <= S_SCAN;
					end
				end
				// one pass over the table: find free/running/best/terminated, or age slots for a tick
				S_SCAN: begin
					unique case (op_t'(req_q.operation))
						OP_CREATE: if (!hit_q && stat_q[idx] == TS_FREE) begin
							hit_q <= 1'b1;
							best_q <= idx;
						end
						OP_SET_EV: if (stat_q[idx] == TS_EVWAIT && aev_q[idx] == ev &&
								(!hit_q || lvl_q[idx] < best_lvl_q ||
								(lvl_q[idx] == best_lvl_q && age > best_age_q))) begin
							hit_q <= 1'b1;
							best_q <= idx;
							best_lvl_q <= lvl_q[idx];
							best_age_q <= age;
						end
						OP_RELEASE: if (stat_q[idx] == TS_TERM) begin
							stat_q[idx] <= TS_FREE;
							if (!hit_q) begin
								hit_q <= 1'b1;
								best_q <= idx;
							end
						end
						OP_TICK: begin
							if (pass_q == 2'd0) begin
								if (stat_q[idx] == TS_READY)
									rdy_q[idx] <= sat_add32(rdy_q[idx], tick_q);
								else if (stat_q[idx] == TS_RUN) begin
									logic [16:0] t;
									t = {1'b0, run_q[idx]} + {9'd0, tick_q};
									run_q[idx] <= t[16] ? 16'hFFFF : t[15:0];
									if ((t[16] ? 16'hFFFF : t[15:0]) >=
											quantum(lvl_q[idx], qh_q, qm_q, ql_q)) begin
										gone_v_q <= 1'b1;
										gone_q <= idx;
									end else begin
										busy_q <= 1'b1;
										run_s_q <= idx;
									end
								end
							end else begin
								// sleepers / waiters; expiring sleepers count down to zero
								if (stat_q[idx] == TS_SLEEP) begin
									wt_q[idx] <= sat_add32(wt_q[idx], tick_q);
									if (sleep_q[idx] <= 16'd1) sleep_q[idx] <= 16'd0;
									else sleep_q[idx] <= sleep_q[idx] - 16'd1;
								end else if (stat_q[idx] == TS_EVWAIT)
									wt_q[idx] <= sat_add32(wt_q[idx], tick_q);
							end
						end
						default: if (stat_q[idx] == TS_RUN) begin
							run_v_q <= 1'b1;
							run_s_q <= idx;
						end
					endcase
					if (last) state_q <= (op_t'(req_q.operation) == OP_TICK) ?
						S_TICK2 : S_APPLY;
					else idx_q <= idx_q + 1'b1;
				end
				S_TICK2: begin
					idx_q <= '0;
					if (pass_q == 2'd0) begin
						if (gone_v_q) begin
							stat_q[gone_q] <= TS_READY;
							run_q[gone_q] <= '0;
							if (lvl_q[gone_q] < 2'd2) lvl_q[gone_q] <= lvl_q[gone_q] + 2'd1;
							stamp_q[gone_q] <= stamp_cnt_q;
							stamp_cnt_q <= stamp_cnt_q + 32'd1;
						end
						pass_q <= 2'd1;
						state_q <= S_SCAN;
					end else begin
						hit_q <= 1'b0;
						state_q <= S_WAKE;
					end
				end
				// wake expired sleepers oldest first, one pass per sleeper
				S_WAKE: begin
					if (!last && stat_q[idx] == TS_SLEEP && sleep_q[idx] == 16'd0 &&
							(!hit_q || age > best_age_q)) begin
						hit_q <= 1'b1;
						best_q <= idx;
						best_age_q <= age;
					end
					if (last) begin
						idx_q <= '0;
						if (hit_q || (stat_q[idx] == TS_SLEEP && sleep_q[idx] == 16'd0 &&
								!hit_q)) begin
							if (hit_q && !(stat_q[idx] == TS_SLEEP && sleep_q[idx] == 16'd0
									&& age > best_age_q)) begin
								stat_q[best_q] <= TS_READY;
								stamp_q[best_q] <= stamp_cnt_q;
							end else begin
								stat_q[idx] <= TS_READY;
								stamp_q[idx] <= stamp_cnt_q;
							end
							stamp_cnt_q <= stamp_cnt_q + 32'd1;
							hit_q <= 1'b0;
						end else if (!busy_q) begin
							disp_lvl_q <= 3'd0;
							hit_q <= 1'b0;
							state_q <= S_DISP;
						end else begin
							st_q <= ST_DONE;
							slot_q <= run_s_q;
							state_q <= S_RESP;
						end
					end else idx_q <= idx_q + 1'b1;
				end
				S_APPLY: begin
					state_q <= S_RESP;
					unique case (op_t'(req_q.operation))
						OP_CREATE: begin
							if (!hit_q) st_q <= ST_FULL;
							else begin
								stat_q[best_q] <= TS_READY;
								lvl_q[best_q] <= (req_q.priority_level == 2'd3) ? 2'd2 :
									req_q.priority_level;
								base_q[best_q] <= (req_q.priority_level == 2'd3) ? 2'd2 :
									req_q.priority_level;
								dfr_q[best_q] <= req_q.deferred_mode;
								creq_q[best_q] <= 1'b0;
								aev_q[best_q] <= '0;
								sleep_q[best_q] <= '0;
								run_q[best_q] <= '0;
								rdy_q[best_q] <= '0;
								wt_q[best_q] <= '0;
								stamp_q[best_q] <= stamp_cnt_q;
								stamp_cnt_q <= stamp_cnt_q + 32'd1;
								st_q <= ST_DONE;
								slot_q <= best_q;
							end
						end
						OP_CANCEL: begin
							if ({28'd0, req_q.target_thread} < THREAD_SLOTS &&
									stat_q[SW'(req_q.target_thread)] != TS_FREE &&
									stat_q[SW'(req_q.target_thread)] != TS_TERM) begin
								if (dfr_q[SW'(req_q.target_thread)])
									creq_q[SW'(req_q.target_thread)] <= 1'b1;
								else stat_q[SW'(req_q.target_thread)] <= TS_TERM;
								st_q <= ST_DONE;
								slot_q <= SW'(req_q.target_thread);
							end
						end
						OP_WAIT_EV, OP_WAIT_TM: if (run_v_q) begin
							if (lvl_q[run_s_q] > 2'd0) lvl_q[run_s_q] <= lvl_q[run_s_q] - 2'd1;
							if (op_t'(req_q.operation) == OP_WAIT_EV) begin
								stat_q[run_s_q] <= TS_EVWAIT;
								aev_q[run_s_q] <= ev;
							end else begin
								stat_q[run_s_q] <= TS_SLEEP;
								sleep_q[run_s_q] <= (req_q.wait_ticks == 16'd0) ? 16'd1 :
									req_q.wait_ticks;
							end
							stamp_q[run_s_q] <= stamp_cnt_q;
							stamp_cnt_q <= stamp_cnt_q + 32'd1;
							st_q <= ST_DONE;
							slot_q <= run_s_q;
							run_v_q <= 1'b0;
							hit_q <= 1'b0;
							idx_q <= '0;
							disp_lvl_q <= 3'd0;
							state_q <= S_DISP;
						end
						OP_TEST_CAN, OP_FINISH:
							if (run_v_q && (op_t'(req_q.operation) == OP_FINISH ||
									creq_q[run_s_q])) begin
								stat_q[run_s_q] <= TS_TERM;
								st_q <= ST_DONE;
								slot_q <= run_s_q;
								run_v_q <= 1'b0;
								hit_q <= 1'b0;
								idx_q <= '0;
								disp_lvl_q <= 3'd0;
								state_q <= S_DISP;
							end
						OP_DISPATCH: if (run_v_q) begin
							st_q <= ST_DONE;
							slot_q <= run_s_q;
						end else begin
							hit_q <= 1'b0;
							idx_q <= '0;
							disp_lvl_q <= 3'd0;
							state_q <= S_DISP;
						end
						OP_SET_EV: if (hit_q) begin
							stat_q[best_q] <= TS_READY;
							stamp_q[best_q] <= stamp_cnt_q;
							stamp_cnt_q <= stamp_cnt_q + 32'd1;
							st_q <= ST_DONE;
							slot_q <= best_q;
						end
						OP_RELEASE: if (hit_q) begin
							st_q <= ST_DONE;
							slot_q <= best_q;
						end
						OP_QUERY: if ({28'd0, req_q.target_thread} < THREAD_SLOTS &&
								stat_q[SW'(req_q.target_thread)] != TS_FREE) begin
							st_q <= ST_DONE;
							slot_q <= SW'(req_q.target_thread);
							detail_q <= 1'b1;
						end
						default: ;
					endcase
				end
				// head search: one pass per level, high first
				S_DISP: begin
					if ((stat_q[idx] == TS_READY || stat_q[idx] == TS_RUN) &&
							lvl_q[idx] == disp_lvl_q[1:0] && (!hit_q || age > best_age_q)) begin
						hit_q <= 1'b1;
						best_q <= idx;
						best_age_q <= age;
					end
					if (last) begin
						idx_q <= '0;
						if (hit_q || ((stat_q[idx] == TS_READY || stat_q[idx] == TS_RUN) &&
								lvl_q[idx] == disp_lvl_q[1:0])) begin
							logic [SW-1:0] h;
							h = (hit_q && !(age > best_age_q &&
								(stat_q[idx] == TS_READY || stat_q[idx] == TS_RUN) &&
								lvl_q[idx] == disp_lvl_q[1:0])) ? best_q : idx;
							stat_q[h] <= TS_RUN;
							disp_q <= 1'b1;
							if (op_t'(req_q.operation) != OP_WAIT_EV &&
									op_t'(req_q.operation) != OP_WAIT_TM &&
									op_t'(req_q.operation) != OP_TEST_CAN &&
									op_t'(req_q.operation) != OP_FINISH) begin
								st_q <= ST_DONE;
								slot_q <= h;
							end
							state_q <= S_RESP;
						end else if (disp_lvl_q == 3'd2) state_q <= S_RESP;
						else disp_lvl_q <= disp_lvl_q + 3'd1;
					end else idx_q <= idx_q + 1'b1;
				end
				S_RESP: begin
					if (!out_valid || out_ready) begin
						out_data <= '0;
						out_data.status <= st_q;
						if (st_q == ST_DONE) begin
							out_data.thread_slot <= 4'(slot_q);
							out_data.dispatched <= disp_q;
							out_data.thread_status <= stat_q[slot_q];
							if (detail_q) begin
								out_data.current_level <= lvl_q[slot_q];
								out_data.base_level <= base_q[slot_q];
								out_data.ready_time <= rdy_q[slot_q];
								out_data.waiting_time <= wt_q[slot_q];
							end
						end
						out_valid <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SCAN))
		else $error("request not started");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && !out_valid) |=> out_valid)
		else $error("response lost");
endmodule
